[design/cu2x_pkg.sv]
package cu2x_pkg;

	localparam int MAX_SMALL_COLS = 1024;
	localparam int MAX_SMALL_ROWS = 1024;

	localparam int COL_W    = $clog2(MAX_SMALL_COLS);
	localparam int ROW_W    = $clog2(MAX_SMALL_ROWS);
	localparam int SAMPLE_W = 8;
	localparam int COORD_W  = 11;
	localparam int CFG_W    = 11;
	localparam int CFG_IDX_W = 2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_SMALL_ROWS = cfg_idx_t'(0);
	localparam cfg_idx_t REG_SMALL_COLS = cfg_idx_t'(1);

	// 2x2 output blocks, in emission order
	typedef enum logic [1:0] {
		BLK_DIAG,
		BLK_LAST_COL,
		BLK_LAST_ROW,
		BLK_CORNER
	} blk_t;

endpackage

[design/cu2x_in_if.sv]
interface cu2x_in_if;
	logic                          valid;
	logic                          ready;
	logic [cu2x_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

[design/cu2x_out_if.sv]
interface cu2x_out_if;
	logic                          valid;
	logic                          ready;
	logic [cu2x_pkg::SAMPLE_W-1:0] pixel_value;
	logic [cu2x_pkg::COORD_W-1:0]  big_row;
	logic [cu2x_pkg::COORD_W-1:0]  big_col;
	logic                          last_of_item;
	logic                          end_of_image;

	modport source (output valid, output pixel_value, output big_row, output big_col,
		output last_of_item, output end_of_image, input ready);
	modport sink (input valid, input pixel_value, input big_row, input big_col,
		input last_of_item, input end_of_image, output ready);
endinterface

[design/cu2x_cfg_if.sv]
interface cu2x_cfg_if;
	logic                       valid;
	logic                       ready;
	cu2x_pkg::cfg_idx_t         reg_index;
	logic [cu2x_pkg::CFG_W-1:0] wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

[design/chroma_upsample_2x_top.sv]
// Results pass the stage-1 register, the block emitter and the output register in turn.
// One result per cycle while the output is ready; a request producing n results (0, 4,
// 8 or 16) holds the block emitter until all are issued, the next one waiting in stage 1.
// The line store is a read-first single-port RAM read and written at the same column.
// Reset clears control, positions, the left and upper-left samples; sizes reset to 1.
// The line store is not cleared; a row or column size write restarts the frame.
module chroma_upsample_2x_top (
	input logic         clk,
	input logic         arst_n,
	cu2x_in_if.sink     chroma,
	cu2x_out_if.source  upsampled,
	cu2x_cfg_if.sink    cfg
);

	localparam int SW = cu2x_pkg::SAMPLE_W;
	localparam int CW = cu2x_pkg::COL_W;
	localparam int RW = cu2x_pkg::ROW_W;
	localparam int XW = cu2x_pkg::COORD_W;

	function automatic int unsigned eff_last(logic [cu2x_pkg::CFG_W-1:0] v, int unsigned maxv);
		int unsigned e;
		e = 32'(v);
		if (e == 0) e = 1;
		if (e > maxv) e = maxv;
		return e - 1;
	endfunction

	function automatic logic [SW-1:0] avg2(logic [SW-1:0] a, logic [SW-1:0] b);
		logic [SW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SW:1];
	endfunction

	logic [CW-1:0] last_col_q;
	logic [RW-1:0] last_row_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [SW-1:0] left_q;
	logic [SW-1:0] upleft_q;

	logic [SW-1:0] line_mem [cu2x_pkg::MAX_SMALL_COLS];

	logic          valid_s1;
	logic [SW-1:0] sample_s1;
	logic [SW-1:0] above_s1;
	logic [RW-1:0] row_s1;
	logic [CW-1:0] col_s1;
	logic [3:0]    mask_s1;

	logic          busy_q;
	logic [3:0]    mask_q;
	logic [1:0]    pix_q;
	logic [SW-1:0] x_q, a_q, l_q, s_q;
	logic [RW-1:0] erow_q;
	logic [CW-1:0] ecol_q;

	logic          out_valid_q;
	logic [SW-1:0] pixel_q;
	logic [XW-1:0] brow_q, bcol_q;
	logic          last_q, eoi_q;

	logic          cfg_fire, in_fire, s1_go, em_load, em_fire, em_last, em_free;
	logic          lc, lr;
	logic [3:0]    mask_in, blk_bit;
	logic [SW-1:0] above_v, pix_v;
	cu2x_pkg::blk_t blk;
	logic [RW-1:0] base_row;
	logic [CW-1:0] base_col;

	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid & cfg.ready;

	assign lc      = (col_q == last_col_q);
	assign lr      = (row_q == last_row_q);
	assign mask_in = {lr & lc, lr & (col_q != '0), (row_q != '0) & lc,
		(row_q != '0) & (col_q != '0)};

	assign em_free      = !busy_q || (em_fire && em_last);
	assign s1_go        = valid_s1 && ((mask_s1 == '0) || em_free);
	assign em_load      = s1_go && (mask_s1 != '0);
	assign chroma.ready = !valid_s1 || s1_go;
	assign in_fire      = chroma.valid & chroma.ready;
	assign above_v      = (row_s1 == '0) ? '0 : above_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= '0;
			last_row_q <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else if (cfg_fire) begin
			unique case (cfg.reg_index)
				cu2x_pkg::REG_SMALL_ROWS: begin
					last_row_q <= RW'(eff_last(cfg.wdata, cu2x_pkg::MAX_SMALL_ROWS));
					col_q      <= '0;
					row_q      <= '0;
				end
				cu2x_pkg::REG_SMALL_COLS: begin
					last_col_q <= CW'(eff_last(cfg.wdata, cu2x_pkg::MAX_SMALL_COLS));
					col_q      <= '0;
					row_q      <= '0;
				end
				default: ;
			endcase
		end else if (in_fire) begin
			if (lc) begin
				col_q <= '0;
				row_q <= lr ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// read-first: the old row comes out while the new sample goes in
	always_ff @(posedge clk) begin
		if (in_fire) begin
			above_s1        <= line_mem[col_q];
			line_mem[col_q] <= chroma.sample;
			sample_s1       <= chroma.sample;
			row_s1          <= row_q;
			col_s1          <= col_q;
			mask_s1         <= mask_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			left_q   <= '0;
			upleft_q <= '0;
		end else begin
			if (in_fire) valid_s1 <= 1'b1;
			else if (s1_go) valid_s1 <= 1'b0;
			if (s1_go) begin
				left_q   <= sample_s1;
				upleft_q <= above_v;
			end
		end
	end

	always_comb begin
		if (mask_q[0]) blk = cu2x_pkg::BLK_DIAG;
		else if (mask_q[1]) blk = cu2x_pkg::BLK_LAST_COL;
		else if (mask_q[2]) blk = cu2x_pkg::BLK_LAST_ROW;
		else blk = cu2x_pkg::BLK_CORNER;
	end

	assign blk_bit = 4'b0001 << blk;
	assign em_fire = busy_q && (!out_valid_q || upsampled.ready);
	assign em_last = (pix_q == 2'd3) && ((mask_q & ~blk_bit) == '0);

	always_comb begin
		pix_v    = s_q;
		base_row = erow_q;
		base_col = ecol_q;
		unique case (blk)
			cu2x_pkg::BLK_DIAG: begin
				base_row = erow_q - 1'b1;
				base_col = ecol_q - 1'b1;
				case (pix_q)
					2'd0:    pix_v = x_q;
					2'd1:    pix_v = avg2(x_q, a_q);
					2'd2:    pix_v = avg2(x_q, l_q);
					default: pix_v = avg2(x_q, s_q);
				endcase
			end
			cu2x_pkg::BLK_LAST_COL: begin
				base_row = erow_q - 1'b1;
				pix_v    = pix_q[1] ? avg2(a_q, s_q) : a_q;
			end
			cu2x_pkg::BLK_LAST_ROW: begin
				base_col = ecol_q - 1'b1;
				pix_v    = pix_q[0] ? avg2(l_q, s_q) : l_q;
			end
			default: pix_v = s_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mask_q <= '0;
			pix_q  <= '0;
		end else if (em_load) begin
			busy_q <= 1'b1;
			mask_q <= mask_s1;
			pix_q  <= '0;
		end else if (em_fire) begin
			pix_q <= pix_q + 1'b1;
			if (pix_q == 2'd3) mask_q <= mask_q & ~blk_bit;
			if (em_last) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (em_load) begin
			x_q    <= upleft_q;
			a_q    <= above_v;
			l_q    <= left_q;
			s_q    <= sample_s1;
			erow_q <= row_s1;
			ecol_q <= col_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (em_fire) begin
			out_valid_q <= 1'b1;
		end else if (upsampled.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (em_fire) begin
			pixel_q <= pix_v;
			brow_q  <= XW'({base_row, pix_q[1]});
			bcol_q  <= XW'({base_col, pix_q[0]});
			last_q  <= em_last;
			eoi_q   <= em_last && (blk == cu2x_pkg::BLK_CORNER);
		end
	end

	assign upsampled.valid        = out_valid_q;
	assign upsampled.pixel_value  = pixel_q;
	assign upsampled.big_row      = brow_q;
	assign upsampled.big_col      = bcol_q;
	assign upsampled.last_of_item = last_q;
	assign upsampled.end_of_image = eoi_q;

endmodule

[design/cu2x_checker.sv]
module cu2x_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [cu2x_pkg::SAMPLE_W-1:0] pixel_value,
	input logic [cu2x_pkg::COORD_W-1:0]  big_row,
	input logic [cu2x_pkg::COORD_W-1:0]  big_col,
	input logic                          last_of_item,
	input logic                          end_of_image
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_value) && $stable(big_row)
			&& $stable(big_col))
		else $error("result changed while stalled");

	a_eoi_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_image |-> last_of_item)
		else $error("end of image without last of request");

	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_item |-> big_row[0] && big_col[0])
		else $error("request ended inside a 2x2 block");

endmodule

bind chroma_upsample_2x_top cu2x_checker u_cu2x_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (upsampled.valid),
	.out_ready    (upsampled.ready),
	.pixel_value  (upsampled.pixel_value),
	.big_row      (upsampled.big_row),
	.big_col      (upsampled.big_col),
	.last_of_item (upsampled.last_of_item),
	.end_of_image (upsampled.end_of_image)
);

[test/cu2x_upsample_check.sv]
module cu2x_upsample_check
	import cu2x_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	cu2x_in_if   chroma,
	cu2x_out_if  upsampled,
	cu2x_cfg_if  cfg,
	output int   errors,
	output int   pending
);

	typedef struct packed {
		logic [SAMPLE_W-1:0] pixel_value;
		logic [COORD_W-1:0]  big_row;
		logic [COORD_W-1:0]  big_col;
		logic                last_of_item;
		logic                end_of_image;
	} px_t;

	px_t                 expected_px[$];
	px_t                 step_px[$];
	logic [SAMPLE_W-1:0] row_above[MAX_SMALL_COLS];
	logic [SAMPLE_W-1:0] left_px;
	logic [SAMPLE_W-1:0] up_left_px;
	logic [CFG_W-1:0]    rows_reg;
	logic [CFG_W-1:0]    cols_reg;
	int unsigned         row_pos;
	int unsigned         col_pos;
	int                  fail_count = 0;

	function automatic int unsigned clamp_size(logic [CFG_W-1:0] v, int unsigned limit);
		if (v == 0)
			return 1;
		if (v > limit)
			return limit;
		return v;
	endfunction

	function automatic logic [SAMPLE_W-1:0] mean2(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b);
		logic [SAMPLE_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[SAMPLE_W:1];
	endfunction

	function automatic void add_block(int unsigned r, int unsigned c,
			logic [SAMPLE_W-1:0] tl, logic [SAMPLE_W-1:0] tr,
			logic [SAMPLE_W-1:0] bl, logic [SAMPLE_W-1:0] br);
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
		y = COORD_W'(2 * r);
		x = COORD_W'(2 * c);
		step_px.push_back('{tl, y, x, 1'b0, 1'b0});
		step_px.push_back('{tr, y, x + 1'b1, 1'b0, 1'b0});
		step_px.push_back('{bl, y + 1'b1, x, 1'b0, 1'b0});
		step_px.push_back('{br, y + 1'b1, x + 1'b1, 1'b0, 1'b0});
	endfunction

	function automatic void upsample_sample(logic [SAMPLE_W-1:0] s);
		int unsigned         nrows;
		int unsigned         ncols;
		int unsigned         r;
		int unsigned         c;
		logic [SAMPLE_W-1:0] above;
		logic [SAMPLE_W-1:0] d;
		logic                corner;
		px_t                 p;
		nrows = clamp_size(rows_reg, MAX_SMALL_ROWS);
		ncols = clamp_size(cols_reg, MAX_SMALL_COLS);
		r = row_pos;
		c = col_pos;
		above = '0;
		corner = 1'b0;
		step_px.delete();
		if (r >= nrows || c >= ncols) begin
			r = 0;
			c = 0;
		end
		if (r > 0)
			above = row_above[c];
		if (r >= 1) begin
			if (c >= 1)
				add_block(r - 1, c - 1, up_left_px, mean2(up_left_px, above),
					mean2(up_left_px, left_px), mean2(up_left_px, s));
			if (c == ncols - 1) begin
				d = mean2(above, s);
				add_block(r - 1, c, above, above, d, d);
			end
		end
		if (r == nrows - 1) begin
			if (c >= 1) begin
				d = mean2(left_px, s);
				add_block(r, c - 1, left_px, d, left_px, d);
			end
			if (c == ncols - 1) begin
				add_block(r, c, s, s, s, s);
				corner = 1'b1;
			end
		end
		for (int i = 0; i < step_px.size(); i++) begin
			p = step_px[i];
			p.last_of_item = (i == step_px.size() - 1);
			p.end_of_image = p.last_of_item && corner;
			expected_px.push_back(p);
		end
		row_above[c] = s;
		up_left_px = above;
		left_px = s;
		c++;
		if (c >= ncols) begin
			c = 0;
			r++;
			if (r >= nrows)
				r = 0;
		end
		row_pos = r;
		col_pos = c;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		px_t want;
		if (!arst_n) begin
			rows_reg = 1;
			cols_reg = 1;
			row_pos = 0;
			col_pos = 0;
			left_px = '0;
			up_left_px = '0;
			for (int i = 0; i < MAX_SMALL_COLS; i++)
				row_above[i] = '0;
			expected_px.delete();
			pending <= 0;
		end else begin
			if (upsampled.valid && upsampled.ready) begin
				if (expected_px.size() == 0) begin
					$error("pixel_value: expected none, got %0d at row %0d col %0d",
						upsampled.pixel_value, upsampled.big_row, upsampled.big_col);
					fail_count++;
				end else begin
					want = expected_px.pop_front();
					check_field("pixel_value", want.pixel_value, upsampled.pixel_value);
					check_field("big_row", want.big_row, upsampled.big_row);
					check_field("big_col", want.big_col, upsampled.big_col);
					check_field("last_of_item", want.last_of_item, upsampled.last_of_item);
					check_field("end_of_image", want.end_of_image, upsampled.end_of_image);
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.reg_index)
					REG_SMALL_ROWS: begin
						rows_reg = cfg.wdata;
						row_pos = 0;
						col_pos = 0;
					end
					REG_SMALL_COLS: begin
						cols_reg = cfg.wdata;
						row_pos = 0;
						col_pos = 0;
					end
					default: ;
				endcase
			end
			if (chroma.valid && chroma.ready)
				upsample_sample(chroma.sample);
			pending <= expected_px.size();
		end
		errors <= fail_count;
	end

endmodule

[test/chroma_upsample_2x_top_tb.sv]
module chroma_upsample_2x_top_tb;
	import cu2x_pkg::*;

	localparam int       CYCLE_LIMIT   = 2_000_000;
	localparam int       SETTLE_CYCLES = 8;
	localparam int       RANDOM_ITEMS  = 150;
	localparam int       EDGE_ITEMS    = 16;
	localparam cfg_idx_t REG_UNUSED    = cfg_idx_t'(3);

	logic clk = 1'b0;
	logic arst_n;
	int   errors;
	int   pending;
	int   idle_pct = 0;
	int   stall_left = 0;
	int   cycles = 0;
	bit   calm = 1'b0;

	cu2x_in_if  chroma_ch();
	cu2x_out_if px_ch();
	cu2x_cfg_if cfg_ch();

	chroma_upsample_2x_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.chroma    (chroma_ch),
		.upsampled (px_ch),
		.cfg       (cfg_ch)
	);

	cu2x_upsample_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.chroma    (chroma_ch),
		.upsampled (px_ch),
		.cfg       (cfg_ch),
		.errors    (errors),
		.pending   (pending)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (calm || !arst_n) begin
			px_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			px_ch.ready <= 1'b0;
		end else if ($urandom_range(99) < idle_pct) begin
			stall_left = $urandom_range(1, 16) - 1;
			px_ch.ready <= 1'b0;
		end else begin
			px_ch.ready <= 1'b1;
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("chroma_upsample_2x_top verification failed");
		$finish;
	end

	task automatic settle();
		do
			@(posedge clk);
		while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
		settle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.wdata <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic write_size(logic [CFG_W-1:0] nr, logic [CFG_W-1:0] nc);
		if ($urandom_range(1)) begin
			write_reg(REG_SMALL_ROWS, nr);
			write_reg(REG_SMALL_COLS, nc);
		end else begin
			write_reg(REG_SMALL_COLS, nc);
			write_reg(REG_SMALL_ROWS, nr);
		end
	endtask

	task automatic send_sample(logic [SAMPLE_W-1:0] s);
		if (!calm && $urandom_range(99) < idle_pct) begin
			chroma_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		chroma_ch.valid <= 1'b1;
		chroma_ch.sample <= s;
		@(posedge clk);
		while (!chroma_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_run(int count);
		logic [SAMPLE_W-1:0] s;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 4))
				0: s = '0;
				1: s = '1;
				default: s = SAMPLE_W'($urandom_range(0, 255));
			endcase
			send_sample(s);
		end
		chroma_ch.valid <= 1'b0;
	endtask

	function automatic logic [CFG_W-1:0] big_size();
		case ($urandom_range(0, 2))
			0: return 1024;
			1: return 2047;
			default: return CFG_W'($urandom_range(1025, 2047));
		endcase
	endfunction

	initial begin
		int               sent;
		int               count;
		int               frame;
		logic [CFG_W-1:0] nr;
		logic [CFG_W-1:0] nc;
		arst_n <= 1'b0;
		chroma_ch.valid <= 1'b0;
		chroma_ch.sample <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.reg_index <= REG_SMALL_ROWS;
		cfg_ch.wdata <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_sample(8'h00);
		send_sample(8'hFF);
		send_sample(8'h55);
		send_sample(8'hAA);
		chroma_ch.valid <= 1'b0;

		write_reg(REG_SMALL_ROWS, 2);
		write_reg(REG_SMALL_COLS, 2);
		send_sample(8'h00);
		send_sample(8'hFF);
		send_sample(8'hFF);
		send_sample(8'h00);
		send_sample(8'hFF);
		send_sample(8'hFF);
		send_sample(8'hFF);
		send_sample(8'hFF);
		send_sample(8'h01);
		send_sample(8'h00);
		chroma_ch.valid <= 1'b0;
		write_reg(REG_UNUSED, '1);
		send_sample(8'h00);
		send_sample(8'h01);
		chroma_ch.valid <= 1'b0;

		write_reg(REG_SMALL_ROWS, 0);
		write_reg(REG_SMALL_COLS, 0);
		send_sample(8'h80);
		send_sample(8'h7F);
		chroma_ch.valid <= 1'b0;

		write_reg(REG_SMALL_ROWS, 3);
		write_reg(REG_SMALL_COLS, 1);
		send_sample(8'hFE);
		send_sample(8'h01);
		send_sample(8'hFF);
		chroma_ch.valid <= 1'b0;

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 3))
				0: idle_pct = 0;
				1: idle_pct = 10;
				2: idle_pct = 35;
				default: idle_pct = 70;
			endcase
			case ($urandom_range(0, 9))
				0: begin
					nr = big_size();
					nc = CFG_W'($urandom_range(0, 4));
					count = $urandom_range(5, 40);
				end
				1: begin
					nr = CFG_W'($urandom_range(0, 4));
					nc = big_size();
					count = $urandom_range(5, 40);
				end
				default: begin
					nr = CFG_W'($urandom_range(0, 6));
					nc = CFG_W'($urandom_range(0, 6));
					frame = (nr == 0 ? 1 : nr) * (nc == 0 ? 1 : nc);
					if ($urandom_range(3) == 0)
						count = $urandom_range(1, 2 * frame);
					else
						count = frame * $urandom_range(1, 2);
				end
			endcase
			write_size(nr, nc);
			send_run(count);
			sent += count;
		end

		idle_pct = 10;
		write_size(1, 2047);
		send_run(EDGE_ITEMS);
		write_size(2047, 1);
		send_run(EDGE_ITEMS);

		calm = 1'b1;
		write_size(3, 4);
		send_run(24);

		settle();
		if (errors == 0)
			$display("chroma_upsample_2x_top verification clean");
		else
			$display("chroma_upsample_2x_top verification failed");
		$finish;
	end

endmodule
